// ===== hdl/qpht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants for the quadratic probing hash table: request
// and result payloads, controller state, and controller/datapath signals.
// ----------------------------------------------------------------------------
package qpht_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 1024;

    localparam int KEY_W    = 31;
    localparam int WORD_W   = KEY_W + 1;
    localparam int CFG_W    = 11;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(1024);

    localparam int DIV_W      = KEY_W + 1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } res_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_SETUP,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic                clear_write;
        logic                load_req;
        logic                div_step;
        logic                probe_start;
        logic                probe_next;
        logic                slot_write;
        logic                result_load;
        logic [STATUS_W-1:0] result_status;
        logic                result_use_slot;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic slot_empty;
        logic slot_match;
        logic last_probe;
        logic command;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/qpht_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_datapath
// Slot store, radix-16 key modulo unit, incremental quadratic probe
// arithmetic, clearing counter and result register.
// ----------------------------------------------------------------------------
module qpht_datapath #(
    parameter int TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire qpht_pkg::req_t                request,
    input  wire logic [qpht_pkg::CFG_W-1:0]    table_size,
    input  wire qpht_pkg::ctrl_cmd_t           cmd,
    output qpht_pkg::dp_status_t               status,
    output qpht_pkg::res_t                     result
);
    import qpht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [KEY_W-1:0]     key_reg;
    logic                 command_reg;
    logic [CFG_W-1:0]     m_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [CFG_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CFG_W-1:0]     pos_reg;
    logic [CFG_W-1:0]     dlt_reg;
    logic [CFG_W-1:0]     probe_cnt_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic [WORD_W-1:0]    rd_data_reg;
    res_t                 result_reg;

    logic [WORD_W-1:0]    mem [TABLE_DEPTH];

    logic [CFG_W-1:0]     m_use;
    logic [CFG_W:0]       part;
    logic [CFG_W-1:0]     rem_next;
    logic [CFG_W:0]       pos_sum;
    logic [CFG_W-1:0]     pos_next;
    logic [CFG_W:0]       dlt_sum;
    logic [CFG_W-1:0]     dlt_next;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_W-1:0]    wr_data;

    always_comb
    begin
        m_use = table_size;
        if (table_size == '0)
        begin
            m_use = CFG_W'(1);
        end
        else if (32'(table_size) > TABLE_DEPTH)
        begin
            m_use = CFG_W'(TABLE_DEPTH);
        end
    end

    always_comb
    begin
        part = {1'b0, rem_reg};
        for (int b = 0; b < DIV_BITS; b++)
        begin
            part = {part[CFG_W-1:0], dvd_reg[DIV_W-1-b]};
            if (part >= {1'b0, m_reg})
            begin
                part = part - {1'b0, m_reg};
            end
        end
        rem_next = part[CFG_W-1:0];
    end

    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + {1'b0, dlt_reg};
        if (pos_sum >= {1'b0, m_reg})
        begin
            pos_sum = pos_sum - {1'b0, m_reg};
        end
        pos_next = pos_sum[CFG_W-1:0];

        dlt_sum = {1'b0, dlt_reg} + (CFG_W+1)'(2);
        if (dlt_sum >= {1'b0, m_reg})
        begin
            dlt_sum = dlt_sum - {1'b0, m_reg};
        end
        if (dlt_sum >= {1'b0, m_reg})
        begin
            dlt_sum = dlt_sum - {1'b0, m_reg};
        end
        dlt_next = dlt_sum[CFG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clear_write)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.load_req)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            key_reg     <= request.key;
            command_reg <= request.command;
            m_reg       <= m_use;
            dvd_reg     <= {1'b0, request.key};
            rem_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= dvd_reg << DIV_BITS;
            rem_reg <= rem_next;
        end

        if (cmd.probe_start)
        begin
            pos_reg       <= rem_reg;
            dlt_reg       <= (m_reg == CFG_W'(1)) ? '0 : CFG_W'(1);
            probe_cnt_reg <= '0;
        end
        else if (cmd.probe_next)
        begin
            pos_reg       <= pos_next;
            dlt_reg       <= dlt_next;
            probe_cnt_reg <= probe_cnt_reg + CFG_W'(1);
        end

        if (cmd.result_load)
        begin
            result_reg.status <= cmd.result_status;
            result_reg.slot   <= cmd.result_use_slot ? pos_reg[SLOT_W-1:0] : '0;
        end
    end

    assign wr_en   = cmd.clear_write | cmd.slot_write;
    assign wr_addr = cmd.clear_write ? clr_cnt_reg : AW'(pos_reg);
    assign wr_data = cmd.clear_write ? '0 : {1'b1, key_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[AW'(pos_reg)];
    end

    assign status.clear_done = (clr_cnt_reg == AW'(TABLE_DEPTH - 1));
    assign status.div_done   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.slot_empty = ~rd_data_reg[WORD_W-1];
    assign status.slot_match = rd_data_reg[WORD_W-1] && (rd_data_reg[KEY_W-1:0] == key_reg);
    assign status.last_probe = (probe_cnt_reg == (m_reg - CFG_W'(1)));
    assign status.command    = command_reg;

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hdl/qpht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ctrl
// Controller for the hash table: clearing pass, request intake, modulo
// steps, probe loop and result handoff.
// ----------------------------------------------------------------------------
module qpht_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 request_valid,
    output logic                      request_ready,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    input  wire qpht_pkg::dp_status_t status,
    output qpht_pkg::ctrl_cmd_t       cmd
);
    import qpht_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;
    logic   finished;

    assign out_free = ~out_valid_reg | result_ready;
    assign finished = status.slot_empty | status.last_probe
                      | ((status.command == CMD_SEARCH) & status.slot_match);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!finished)
                begin
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        request_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
            end
            S_IDLE:
            begin
                request_ready = 1'b1;
                cmd.load_req  = request_valid;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_SETUP:
            begin
                cmd.probe_start = 1'b1;
            end
            S_READ:
            begin
            end
            S_CHECK:
            begin
                if (!finished)
                begin
                    cmd.probe_next = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    if (status.command == CMD_INSERT)
                    begin
                        if (status.slot_empty)
                        begin
                            cmd.slot_write      = 1'b1;
                            cmd.result_status   = STATUS_INSERTED;
                            cmd.result_use_slot = 1'b1;
                        end
                        else
                        begin
                            cmd.result_status = STATUS_FULL;
                        end
                    end
                    else
                    begin
                        if (!status.slot_empty && status.slot_match)
                        begin
                            cmd.result_status   = STATUS_FOUND;
                            cmd.result_use_slot = 1'b1;
                        end
                        else
                        begin
                            cmd.result_status = STATUS_NOT_FOUND;
                        end
                    end
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/quadratic_probe_hash_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table
// Steps: 8 modulo steps, 1 setup, then a read and a check per slot store probe;
// the check holds while an earlier result still waits to be taken.
// A new request is taken only after the last one is done; a waiting result
// does not block intake of the next request.
// Reset: clears every one of the TABLE_DEPTH slot store entries, with no
// request taken until it ends; table_size resets to 1024.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table #(
    parameter int TABLE_DEPTH = qpht_pkg::TABLE_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       request_valid,
    output logic                            request_ready,
    input  wire qpht_pkg::req_t             request,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output qpht_pkg::res_t                  result,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [qpht_pkg::CFG_W-1:0] cfg_data
);
    import qpht_pkg::*;

    logic [CFG_W-1:0] table_size_reg;
    ctrl_cmd_t        cmd;
    dp_status_t       status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            table_size_reg <= cfg_data;
        end
    end

    qpht_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .cmd           (cmd)
    );

    qpht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .table_size (table_size_reg),
        .cmd        (cmd),
        .status     (status),
        .result     (result)
    );

endmodule

`default_nettype wire
